// ----- design/dbc_pkg.sv -----
// Shared types, character tables and polymod helpers for the descriptor checksum block.
package dbc_pkg;

   localparam int CHECK_W    = 40;
   localparam int SYM_W      = 5;
   localparam int CHARSET_N  = 95;
   localparam int OUTSET_N   = 32;
   localparam int CHECK_SYMS = 8;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       error;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] pos;
   } lookup_type;

   // First character sits in the top byte; the last five are the backtick, hash,
   // double quote, backslash and space.
   localparam logic [CHARSET_N*8-1:0] INPUT_SET = {
      "0123456789()[],'/*abcdefgh@:$%{}",
      "IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
      "ijklmnopqrstuvwxyzABCDEFGH",
      8'h60, 8'h23, 8'h22, 8'h5c, 8'h20
   };

   localparam logic [OUTSET_N*8-1:0] OUTPUT_SET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   localparam logic [CHECK_W-1:0] GEN_POLY [SYM_W] = '{
      40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
      40'h3706b1677a, 40'h644d626ffd
   };

   function automatic logic [CHECK_W-1:0] fold(input logic [CHECK_W-1:0] acc,
                                               input logic [SYM_W-1:0]   sym);
      logic [SYM_W-1:0]   top;
      logic [CHECK_W-1:0] res;
      top = acc[CHECK_W-1 -: SYM_W];
      res = {acc[CHECK_W-SYM_W-1:0], sym};
      for (int b = 0; b < SYM_W; b++) begin
         if (top[b]) begin
            res = res ^ GEN_POLY[b];
         end
      end
      return res;
   endfunction

   // Position of a byte in the input charset; entries are distinct, so at most one hits.
   function automatic lookup_type char_lookup(input logic [7:0] ch);
      lookup_type r;
      r = '0;
      for (int i = 0; i < CHARSET_N; i++) begin
         if (ch == INPUT_SET[(CHARSET_N-1-i)*8 +: 8]) begin
            r.valid = 1'b1;
            r.pos   = 7'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] out_char(input logic [SYM_W-1:0] idx);
      logic [7:0] c;
      c = '0;
      for (int i = 0; i < OUTSET_N; i++) begin
         if (idx == SYM_W'(i)) begin
            c = OUTPUT_SET[(OUTSET_N-1-i)*8 +: 8];
         end
      end
      return c;
   endfunction

endpackage

// ----- design/descriptor_bch_checksum.sv -----
// Descriptor checksum generator: charset lookup, BCH polymod and checksum emitter.
//
//  channel | direction | payload              | handshake
//  req     | in        | dbc_pkg::req_type    | req_valid / req_stall
//  rsp     | out       | dbc_pkg::rsp_type    | rsp_valid / rsp_stall
//
// Body characters are taken one per cycle; lookup and up to two polymod folds
// finish in the cycle of acceptance.
// An end beat loads the emitter, which runs eight zero-symbol folds at one per
// cycle and then sends eight symbol beats (one beat on an error run). A further
// end beat stalls until the emitter has loaded its last beat into the output
// register; body characters keep flowing meanwhile.
// Reset is synchronous and active high; it clears the accumulator to one and
// empties the emitter and output register. rsp_stall holds the output register.
module descriptor_bch_checksum (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dbc_pkg::rsp_type rsp_data
);

   localparam logic PH_FOLD = 1'b0;
   localparam logic PH_SEND = 1'b1;

   // running state of the current body
   logic [dbc_pkg::CHECK_W-1:0] check_ff, check_in;
   logic [dbc_pkg::SYM_W-1:0]   group_ff, group_in;
   logic [1:0]                  count_ff, count_in;
   logic                        bad_ff, bad_in;

   // emitter
   logic                        busy_ff, busy_in;
   logic                        phase_ff, phase_in;
   logic [2:0]                  step_ff, step_in;
   logic                        err_ff, err_in;
   logic [dbc_pkg::CHECK_W-1:0] emit_ff, emit_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   dbc_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        accept;
   logic                        end_accept;
   logic                        rsp_load;
   logic                        beat;
   dbc_pkg::lookup_type         hit;
   logic [dbc_pkg::CHECK_W-1:0] char_fold;
   logic [dbc_pkg::SYM_W-1:0]   group_next;
   logic [dbc_pkg::CHECK_W-1:0] flushed;
   logic [dbc_pkg::CHECK_W-1:0] zero_fold;

   // Stall an end beat only while the emitter still owns an earlier checksum.
   assign req_stall  = (req_data.kind == dbc_pkg::KIND_END) && busy_ff;
   assign accept     = req_valid && !req_stall;
   assign end_accept = accept && (req_data.kind == dbc_pkg::KIND_END);

   assign rsp_load = !rsp_valid_ff || !rsp_stall;
   assign beat     = busy_ff && (phase_ff == PH_SEND) && rsp_load;

   assign hit        = dbc_pkg::char_lookup(req_data.character);
   assign char_fold  = dbc_pkg::fold(check_ff, hit.pos[dbc_pkg::SYM_W-1:0]);
   // group * 3 + class, kept to five bits
   assign group_next = dbc_pkg::SYM_W'({group_ff, 1'b0} + {1'b0, group_ff}
                                       + {4'b0, hit.pos[6:5]});
   assign flushed    = (count_ff != 2'd0) ? dbc_pkg::fold(check_ff, group_ff) : check_ff;
   assign zero_fold  = dbc_pkg::fold(emit_ff, '0);

   // Body state: fold each character, and the class group after every third one.
   always_comb begin
      check_in = check_ff;
      group_in = group_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      if (end_accept) begin
         check_in = dbc_pkg::CHECK_W'(1);
         group_in = '0;
         count_in = '0;
         bad_in   = 1'b0;
      end else if (accept && !bad_ff) begin
         if (!hit.valid) begin
            bad_in = 1'b1;
         end else if (count_ff == 2'd2) begin
            check_in = dbc_pkg::fold(char_fold, group_next);
            group_in = '0;
            count_in = '0;
         end else begin
            check_in = char_fold;
            group_in = group_next;
            count_in = count_ff + 2'd1;
         end
      end
   end

   // Emitter: finish the polymod, then shift out one symbol per beat.
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      err_in   = err_ff;
      emit_in  = emit_ff;
      if (end_accept) begin
         busy_in  = 1'b1;
         step_in  = '0;
         err_in   = bad_ff;
         emit_in  = flushed;
         phase_in = bad_ff ? PH_SEND : PH_FOLD;
      end else if (busy_ff) begin
         unique case (phase_ff)
            PH_FOLD: begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  emit_in  = zero_fold ^ dbc_pkg::CHECK_W'(1);
                  phase_in = PH_SEND;
               end else begin
                  emit_in = zero_fold;
               end
            end
            PH_SEND: begin
               if (beat) begin
                  step_in = step_ff + 3'd1;
                  emit_in = {emit_ff[dbc_pkg::CHECK_W-dbc_pkg::SYM_W-1:0],
                             dbc_pkg::SYM_W'(0)};
                  if (err_ff || step_ff == 3'd7) begin
                     busy_in = 1'b0;
                  end
               end
            end
            default: begin
               phase_in = PH_FOLD;
            end
         endcase
      end
   end

   // Output register: load a fresh beat when empty or when the current one is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = beat;
         if (err_ff) begin
            rsp_in.symbol = '0;
            rsp_in.error  = 1'b1;
            rsp_in.last   = 1'b1;
         end else begin
            rsp_in.symbol = dbc_pkg::out_char(emit_ff[dbc_pkg::CHECK_W-1 -: dbc_pkg::SYM_W]);
            rsp_in.error  = 1'b0;
            rsp_in.last   = (step_ff == 3'd7);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff     <= dbc_pkg::CHECK_W'(1);
         group_ff     <= '0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         phase_ff     <= PH_FOLD;
         step_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         check_ff     <= check_in;
         group_ff     <= group_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      emit_ff <= emit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_end_starts_emitter: assert property (@(posedge clock) disable iff (reset)
      end_accept |=> busy_ff)
      else $error("end beat did not start the emitter");

   a_end_restores_state: assert property (@(posedge clock) disable iff (reset)
      end_accept |=> (check_ff == dbc_pkg::CHECK_W'(1)) && (count_ff == 2'd0)
                     && (group_ff == '0) && !bad_ff)
      else $error("body state not restored after end beat");

   a_error_beat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.last && (rsp_ff.symbol == 8'd0))
      else $error("error beat malformed");

   a_symbol_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.error |-> (rsp_ff.symbol != 8'd0))
      else $error("checksum beat carries no character");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the descriptor checksum block: directed table, then random bodies.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either channel
   localparam int BODY_ITEMS  = 360;
   localparam int TAIL_CYCLES = 40;    // tail after the last owed beat, to catch strays

   // Descriptor charset in position order; the last five are backtick, hash,
   // double quote, backslash and space.
   localparam logic [95*8-1:0] BODY_CHARS = {
      "0123456789()[],'/*abcdefgh@:$%{}",
      "IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
      "ijklmnopqrstuvwxyzABCDEFGH",
      8'h60, 8'h23, 8'h22, 8'h5c, 8'h20
   };
   localparam logic [32*8-1:0] SUM_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [39:0] BCH_GEN [5] = '{
      40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d, 40'h3706b1677a, 40'h644d626ffd
   };

   localparam dbc_pkg::rsp_type NO_BEAT    = '0;
   localparam dbc_pkg::rsp_type ERROR_BEAT = {8'h00, 1'b1, 1'b1};

   // One row of the directed script: when typed is set, the beat expected is
   // the one written in the row rather than the one the predictor works out.
   typedef struct packed {
      logic             typed;
      dbc_pkg::rsp_type want;
      dbc_pkg::req_type beat;
   } script_row_type;

   localparam int SCRIPT_N = 23;
   localparam script_row_type SCRIPT [SCRIPT_N] = '{
      {1'b0, NO_BEAT,    dbc_pkg::KIND_END,  8'h00},  // empty body straight after reset
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "0"},    // first charset entry, class 0
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "~"},    // position 63, class 1
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h20},  // last entry (space), class 2
      {1'b0, NO_BEAT,    dbc_pkg::KIND_END,  8'hff},  // character field ignored on end
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "a"},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_END,  8'h00},  // partial group of one flushed
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "I"},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "j"},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_END,  8'h5a},  // partial group of two flushed
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h00},  // bad as first character of a body
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "x"},    // ignored after a bad character
      {1'b1, ERROR_BEAT, dbc_pkg::KIND_END,  8'h00},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "Q"},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'hff},  // bad in the middle of a group
      {1'b1, ERROR_BEAT, dbc_pkg::KIND_END,  8'hff},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h7f},
      {1'b1, ERROR_BEAT, dbc_pkg::KIND_END,  8'h00},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h5c},  // the awkward quoting characters
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h22},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, 8'h60},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_CHAR, "#"},
      {1'b0, NO_BEAT,    dbc_pkg::KIND_END,  8'h00}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dbc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dbc_pkg::rsp_type rsp_data;

   // Predictor state, cleared as the block clears it.
   logic [39:0] polymod_acc = 40'd1;
   logic [4:0]  class_acc   = '0;
   logic [1:0]  class_n     = '0;
   logic        body_bad    = 1'b0;

   dbc_pkg::rsp_type checksum_q [$];  // symbol beats still owed by the block
   dbc_pkg::rsp_type fresh_q [$];     // beats caused by the beat just accepted
   int               faults = 0;

   descriptor_bch_checksum uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // One polymod step over GF(32): shift in a symbol, reduce by the top five bits.
   function automatic logic [39:0] bch_step(input logic [39:0] acc, input logic [4:0] sym);
      logic [39:0] nxt;
      nxt = {acc[34:0], sym};
      for (int b = 0; b < 5; b++) begin
         if (acc[35 + b]) begin
            nxt = nxt ^ BCH_GEN[b];
         end
      end
      return nxt;
   endfunction

   function automatic int charset_pos(input logic [7:0] ch);
      for (int i = 0; i < 95; i++) begin
         if (BODY_CHARS[(94 - i)*8 +: 8] == ch) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic int pick_gap(input bit burst);
      return burst ? 0 : int'($urandom_range(0, 12));
   endfunction

   task automatic clear_predictor();
      polymod_acc = 40'd1;
      class_acc   = '0;
      class_n     = '0;
      body_bad    = 1'b0;
   endtask

   // Advance the predictor by one accepted beat; any beats owed land in fresh_q.
   task automatic absorb_beat(input dbc_pkg::req_type b);
      int               pos;
      int               packed_cls;
      dbc_pkg::rsp_type r;
      if (b.kind == dbc_pkg::KIND_CHAR) begin
         if (!body_bad) begin
            pos = charset_pos(b.character);
            if (pos < 0) begin
               body_bad = 1'b1;
            end else begin
               polymod_acc = bch_step(polymod_acc, pos[4:0]);
               packed_cls  = int'(class_acc) * 3 + pos / 32;
               class_acc   = packed_cls[4:0];
               class_n     = class_n + 2'd1;
               if (class_n == 2'd3) begin
                  polymod_acc = bch_step(polymod_acc, class_acc);
                  class_acc   = '0;
                  class_n     = '0;
               end
            end
         end
      end else if (body_bad) begin
         fresh_q = {fresh_q, ERROR_BEAT};
         clear_predictor();
      end else begin
         // flush a partial class group, pad with eight zero symbols, flip bit 0
         if (class_n != 2'd0) begin
            polymod_acc = bch_step(polymod_acc, class_acc);
         end
         repeat (8) polymod_acc = bch_step(polymod_acc, 5'd0);
         polymod_acc = polymod_acc ^ 40'd1;
         for (int k = 0; k < 8; k++) begin
            r.symbol = SUM_ALPHABET[(31 - int'(polymod_acc[5*(7 - k) +: 5]))*8 +: 8];
            r.error  = 1'b0;
            r.last   = (k == 7);
            fresh_q  = {fresh_q, r};
         end
         clear_predictor();
      end
   endtask

   // Present one request beat after an idle gap and hold it until taken.
   // Called and returns at a falling edge.
   task automatic send_beat(input dbc_pkg::req_type b, input int gap, input logic typed,
                            input dbc_pkg::rsp_type want);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      absorb_beat(b);
      if (typed) begin
         checksum_q = {checksum_q, want};
      end else begin
         checksum_q = {checksum_q, fresh_q};
      end
      fresh_q.delete();
      @(negedge clock);
   endtask

   // Drop valid and hold off until the block has sent everything owed.
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(negedge clock);
      while (checksum_q.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      dbc_pkg::req_type b;
      bit               burst;
      bit               noisy;
      int               body_len;
      int               counted;
      counted = SCRIPT_N;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script
      burst = 1'b0;
      for (int idx = 0; idx < SCRIPT_N; idx++) begin
         if (idx % 8 == 0) burst = !burst;
         send_beat(SCRIPT[idx].beat, pick_gap(burst), SCRIPT[idx].typed, SCRIPT[idx].want);
      end
      drain_pause();

      // random bodies: mostly charset characters, now and then a stray byte,
      // a few noisy bodies and an occasional long one
      while (counted < BODY_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 11) == 0) drain_pause();
         body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         noisy    = ($urandom_range(0, 7) == 0);
         for (int k = 0; k < body_len; k++) begin
            b.kind = dbc_pkg::KIND_CHAR;
            if ((noisy && $urandom_range(0, 4) == 0) || $urandom_range(0, 59) == 0) begin
               b.character = 8'($urandom_range(0, 255));
            end else begin
               b.character = BODY_CHARS[(94 - $urandom_range(0, 94))*8 +: 8];
            end
            counted++;
            send_beat(b, pick_gap(burst), 1'b0, NO_BEAT);
         end
         b.kind      = dbc_pkg::KIND_END;
         b.character = 8'($urandom_range(0, 255));
         counted++;
         send_beat(b, pick_gap(burst), 1'b0, NO_BEAT);
      end
      req_valid <= 1'b0;

      // wait out every owed beat, then a tail to catch strays
      while (checksum_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Result side: stall for a random spell before each beat, with calm stretches.
   initial begin : rsp_sink
      int hold;
      bit calm;
      calm = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         hold = pick_gap(calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Compare each result beat with the oldest one owed, field by field.
   always @(posedge clock) begin : rsp_check
      dbc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (checksum_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
            faults++;
         end else begin
            want = checksum_q.pop_front();
            if (rsp_data.symbol !== want.symbol) begin
               $display("%0t: symbol expected %h actual %h", $time, want.symbol,
                        rsp_data.symbol);
               faults++;
            end
            if (rsp_data.error !== want.error) begin
               $display("%0t: error expected %b actual %b", $time, want.error, rsp_data.error);
               faults++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_data.last);
               faults++;
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/dbc_pkg.sv
design/descriptor_bch_checksum.sv
verif/tb_top.sv
